@@ hw/rtl/scan_window_peak_finder_unit_defines.svh @@
// assertion macros for the scan window peak finder
`ifndef SCAN_WINDOW_PEAK_FINDER_UNIT_DEFINES_SVH
`define SCAN_WINDOW_PEAK_FINDER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SWPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swpf assertion failed");

// next-cycle implication, checked outside reset
`define SWPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swpf assertion failed");

`endif

@@ hw/rtl/swpf_pkg.sv @@
// shared widths, types and codes of the scan window peak finder
package swpf_pkg;

    localparam int RANGE_W   = 16;
    localparam int INTEN_W   = 16;
    localparam int START_W   = 12;
    localparam int SUM_W     = 18;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int WINDOW_LEN_DEF = 4;

    localparam logic [SUM_W-1:0]   SUM_MAX       = '1;
    localparam logic [RANGE_W-1:0] RANGE_MIN_RST = '0;
    localparam logic [RANGE_W-1:0] RANGE_MAX_RST = '1;
    localparam logic [SUM_W-1:0]   SUM_THR_RST   = 18'd90;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN = 2'd0,
        CFG_RANGE_MAX = 2'd1,
        CFG_SUM_THR   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [RANGE_W-1:0] rng_lo;
        logic [RANGE_W-1:0] rng_hi;
        logic [SUM_W-1:0]   sum_thr;
    } t_cfg;

    typedef struct packed {
        logic step;
        logic last;
    } t_step_ctl;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] best_start;
        logic [SUM_W-1:0]   best_sum;
    } t_result;

endpackage

@@ hw/rtl/swpf_pt_if.sv @@
// scan point channel
interface swpf_pt_if;
    logic                          valid;
    logic                          ready;
    logic [swpf_pkg::RANGE_W-1:0]  range_mm;
    logic [swpf_pkg::INTEN_W-1:0]  intensity;
    logic                          last_point;

    modport source (output valid, range_mm, intensity, last_point, input ready);
    modport sink   (input valid, range_mm, intensity, last_point, output ready);
endinterface

@@ hw/rtl/swpf_res_if.sv @@
// scan result channel
interface swpf_res_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [swpf_pkg::START_W-1:0]  best_start;
    logic [swpf_pkg::SUM_W-1:0]    best_sum;

    modport source (output valid, found, best_start, best_sum, input ready);
    modport sink   (input valid, found, best_start, best_sum, output ready);
endinterface

@@ hw/rtl/swpf_window.sv @@
// window history, sum and best-window tracking for one scan
module swpf_window #(
    parameter int MAX_POINTS = swpf_pkg::MAX_POINTS_DEF,
    parameter int WINDOW_LEN = swpf_pkg::WINDOW_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  swpf_pkg::t_cfg               i_cfg,
    input  swpf_pkg::t_step_ctl          i_ctl,
    input  logic [swpf_pkg::RANGE_W-1:0] i_range,
    input  logic [swpf_pkg::INTEN_W-1:0] i_intensity,
    output swpf_pkg::t_result            o_res
);
    import swpf_pkg::*;

    localparam int HIST_LEN = WINDOW_LEN - 1;
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int ACC_W    = SUM_W + $clog2(WINDOW_LEN);

    logic [HIST_LEN-1:0] r_hist_vld;
    logic [INTEN_W-1:0]  r_hist_int [HIST_LEN];
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_best_sum;
    logic [START_W-1:0]  r_best_start;
    logic                r_have_best;

    logic [SUM_W-1:0]    n_best_sum;
    logic [START_W-1:0]  n_best_start;
    logic                n_have_best;

    logic                pt_ok;
    logic                take;
    logic                better;
    logic [ACC_W-1:0]    acc;
    logic [SUM_W-1:0]    win_sum;

    always_comb begin
        pt_ok = (i_range >= i_cfg.rng_lo) && (i_range <= i_cfg.rng_hi);
        acc = ACC_W'(i_intensity);
        for (int k = 0; k < HIST_LEN; k++) begin
            acc = acc + ACC_W'(r_hist_int[k]);
        end
        win_sum = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
        // points past the cap are ignored, only the last mark still counts
        take   = i_ctl.step && (r_count < CNT_W'(MAX_POINTS));
        better = take && (r_count >= CNT_W'(HIST_LEN)) && pt_ok && (&r_hist_vld)
                 && (win_sum > i_cfg.sum_thr) && (win_sum > r_best_sum);
        n_best_sum   = better ? win_sum : r_best_sum;
        n_best_start = better ? START_W'(r_count - CNT_W'(HIST_LEN)) : r_best_start;
        n_have_best  = better || r_have_best;
        o_res.found      = n_have_best;
        o_res.best_start = n_best_start;
        o_res.best_sum   = n_best_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld   <= '0;
            r_count      <= '0;
            r_best_sum   <= '0;
            r_best_start <= '0;
            r_have_best  <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_ctl.last) begin
                r_hist_vld   <= '0;
                r_count      <= '0;
                r_best_sum   <= '0;
                r_best_start <= '0;
                r_have_best  <= 1'b0;
            end else if (take) begin
                for (int k = HIST_LEN - 1; k > 0; k--) begin
                    r_hist_vld[k] <= r_hist_vld[k-1];
                end
                r_hist_vld[0] <= pt_ok;
                r_count       <= r_count + 1'b1;
                r_best_sum    <= n_best_sum;
                r_best_start  <= n_best_start;
                r_have_best   <= n_have_best;
            end
        end
    end

    // intensity history needs no reset, it is only summed once the count says it is full
    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int k = HIST_LEN - 1; k > 0; k--) begin
                r_hist_int[k] <= r_hist_int[k-1];
            end
            r_hist_int[0] <= i_intensity;
        end
    end

endmodule

@@ hw/rtl/scan_window_peak_finder_unit.sv @@
// top level of the scan window peak finder
// Scan points enter on i_pt (valid/ready), one beat per point, the last
// point of a scan flagged by last_point. For each scan one result beat
// leaves on o_res: found, start index and sum of the strongest window of
// WINDOW_LEN consecutive in-range points whose sum exceeds the threshold.
// Registers (range_min_mm, range_max_mm, sum_threshold) are written on the
// plain write port i_cfg_we/i_cfg_idx/i_cfg_data. The user must write them
// only while no scan is running; the block itself does not enforce it.
// Throughput: one point per cycle, set by the single window adder chain
// between the input register and the scan state, except when a last point is held as below.
// The last point's beat passes the input register, then the result register,
// which raises o_res.valid. Reset puts the registers at their defaults,
// clears the scan state and empties both pipeline registers.
// When o_res stalls, the result register holds and the points of the next
// scan keep flowing; only a further last point waits in the input
// register, which then drops i_pt.ready until the result is taken.
`include "scan_window_peak_finder_unit_defines.svh"

module scan_window_peak_finder_unit #(
    parameter int MAX_POINTS = swpf_pkg::MAX_POINTS_DEF,
    parameter int WINDOW_LEN = swpf_pkg::WINDOW_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    swpf_pt_if.sink                        i_pt,
    swpf_res_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [swpf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [swpf_pkg::CFG_W-1:0]     i_cfg_data
);
    import swpf_pkg::*;

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic               r_in_last;
    logic [RANGE_W-1:0] r_in_range;
    logic [INTEN_W-1:0] r_in_int;
    logic               r_out_valid;
    t_result            r_out;

    logic               adv;
    t_step_ctl          step_ctl;
    t_result            res;

    // a last point may only move on when the result register can take it
    assign adv = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign i_pt.ready = !r_in_valid || adv;

    assign step_ctl.step = adv;
    assign step_ctl.last = r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rng_lo  <= RANGE_MIN_RST;
            r_cfg.rng_hi  <= RANGE_MAX_RST;
            r_cfg.sum_thr <= SUM_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_MIN: r_cfg.rng_lo  <= i_cfg_data[RANGE_W-1:0];
                CFG_RANGE_MAX: r_cfg.rng_hi  <= i_cfg_data[RANGE_W-1:0];
                CFG_SUM_THR:   r_cfg.sum_thr <= i_cfg_data[SUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pt.ready) begin
            r_in_valid <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pt.valid && i_pt.ready) begin
            r_in_last  <= i_pt.last_point;
            r_in_range <= i_pt.range_mm;
            r_in_int   <= i_pt.intensity;
        end
    end

    swpf_window #(
        .MAX_POINTS (MAX_POINTS),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_ctl       (step_ctl),
        .i_range     (r_in_range),
        .i_intensity (r_in_int),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.found      = r_out.found;
    assign o_res.best_start = r_out.best_start;
    assign o_res.best_sum   = r_out.best_sum;

    `SWPF_ASSERT_IMP(a_nofind_zero, r_out_valid && !r_out.found, (r_out.best_sum == '0) && (r_out.best_start == '0))
    `SWPF_ASSERT_NXT(a_last_loads_out, adv && r_in_last, r_out_valid)
    `SWPF_ASSERT_IMP(a_stall_cause, !i_pt.ready, r_in_valid && r_in_last && r_out_valid && !o_res.ready)

endmodule
